// File: hdl/lcg_pkg.sv
// shared constants, types and helper functions for the lcg string generator
package lcg_pkg;

  // generator constants
  localparam int unsigned DRAW_W  = 31;
  localparam logic [31:0] LCG_MOD = 32'd2147483647;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;
  localparam logic [DRAW_W-1:0] SEED_RESET = 31'd1;

  // string shape
  localparam int unsigned MIN_LENGTH    = 5;
  localparam int unsigned LENGTH_SPAN   = 6;
  localparam int unsigned MAX_CHARS     = 10;
  localparam int unsigned ALPHABET_SIZE = 62;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned DIV_W         = 6;

  // request token queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // reciprocals for exact division of a 31-bit draw by a small constant
  localparam int unsigned SPAN_SHIFT  = $clog2(LENGTH_SPAN);
  localparam int unsigned ALPHA_SHIFT = $clog2(ALPHABET_SIZE);
  localparam logic [32:0] SPAN_RECIP  =
    33'(((64'd1 << (DRAW_W + SPAN_SHIFT)) + 64'(LENGTH_SPAN) - 64'd1) / 64'(LENGTH_SPAN));
  localparam logic [32:0] ALPHA_RECIP =
    33'(((64'd1 << (DRAW_W + ALPHA_SHIFT)) + 64'(ALPHABET_SIZE) - 64'd1) /
        64'(ALPHABET_SIZE));

  // alphabet boundaries
  localparam logic [DIV_W-1:0]  NUM_LOWER   = 6'd26;
  localparam logic [DIV_W-1:0]  NUM_LETTERS = 6'd52;
  localparam logic [CHAR_W-1:0] ASCII_LOW_A = 7'd97;
  localparam logic [CHAR_W-1:0] ASCII_UP_A  = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN_WAIT,
    ST_CHARS
  } seq_state_e;

  // one draw moving through the reduction pipeline
  typedef struct packed {
    logic              valid;
    logic              is_len;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [DRAW_W-1:0] draw;
  } draw_item_t;

  // one step of s = (a*s + c) mod (2^31-1), folding the high part back in
  function automatic logic [DRAW_W-1:0] lcg_next(logic [DRAW_W-1:0] s);
    logic [52:0] prod;
    logic [31:0] fold;
    prod = 53'(s) * 53'(LCG_MUL) + 53'(LCG_INC);
    fold = 32'(prod[52:31]) + 32'(prod[30:0]);
    if (fold >= LCG_MOD) begin
      fold = fold - LCG_MOD;
    end
    return fold[DRAW_W-1:0];
  endfunction

  // alphabet index to ascii: lowercase, uppercase, digits
  function automatic logic [CHAR_W-1:0] alpha_char(logic [DIV_W-1:0] idx);
    logic [CHAR_W-1:0] code;
    if (idx < NUM_LOWER) begin
      code = ASCII_LOW_A + 7'(idx);
    end else if (idx < NUM_LETTERS) begin
      code = ASCII_UP_A + 7'(idx - NUM_LOWER);
    end else begin
      code = ASCII_ZERO + 7'(idx - NUM_LETTERS);
    end
    return code;
  endfunction

endpackage

// File: hdl/lcg_random_string_generator.sv
// Random alphanumeric string generator, top level.
// Input channel: in_valid_i / in_stall_o with request_i. A transfer with request_i
// high asks for one string; one with request_i low is taken and dropped. Up to four
// requests queue up while a string is being made.
// Output channel: out_valid_o / out_stall_i, one transfer per character with
// char_code_o, string_length_o (5 to 10) and last_char_o set on the final one.
// Seed port: seed_we_i loads seed_value_i into the generator at once; write it only
// while no string is pending.
// Path of a string: its request is counted in the queue, the length draw passes
// the b_q and c_q stages, and each character draw then passes b_q, c_q and the
// output register. Strings are made one after another: the generator loop takes
// one step per cycle while the output is not stalled (one for the length, one per
// character) and waits for the length to come out of the remainder stage.
// Reset: the generator state becomes 1, the queue empties, no output is valid.
// Output stall: the whole back end halts with the output register; the generator
// does not step, and requests keep queuing until the queue is full.
module lcg_random_string_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lcg_pkg::CHAR_W-1:0]    char_code_o,
  output logic [lcg_pkg::LEN_W-1:0]     string_length_o,
  output logic                          last_char_o,
  input  logic                          seed_we_i,
  input  logic [lcg_pkg::DRAW_W-1:0]    seed_value_i
);

  logic tok_avail;
  logic pop;

  lcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .request_i   (request_i),
    .tok_avail_o (tok_avail),
    .pop_i       (pop)
  );

  lcg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_avail_i     (tok_avail),
    .pop_o           (pop),
    .seed_we_i       (seed_we_i),
    .seed_value_i    (seed_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .char_code_o     (char_code_o),
    .string_length_o (string_length_o),
    .last_char_o     (last_char_o)
  );

endmodule

// File: hdl/lcg_front.sv
// request intake: drops empty requests and queues request tokens for the back end
module lcg_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic request_i,
  output logic tok_avail_o,
  input  logic pop_i
);

  logic [lcg_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      push;

  assign in_stall_o  = (cnt_q == lcg_pkg::CNT_W'(lcg_pkg::QUEUE_DEPTH));
  assign tok_avail_o = (cnt_q != '0);
  // a transfer with request low leaves no token
  assign push        = in_valid_i && !in_stall_o && request_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lcg_pkg::CNT_W'(lcg_pkg::QUEUE_DEPTH))
    else $error("request queue over depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty request queue");

endmodule

// File: hdl/lcg_back.sv
// generator sequencer, draw reduction pipeline and output register
module lcg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tok_avail_i,
  output logic                              pop_o,
  input  logic                              seed_we_i,
  input  logic [lcg_pkg::DRAW_W-1:0]        seed_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lcg_pkg::CHAR_W-1:0]        char_code_o,
  output logic [lcg_pkg::LEN_W-1:0]         string_length_o,
  output logic                              last_char_o
);

  lcg_pkg::seq_state_e          state_q, state_d;
  logic [lcg_pkg::DRAW_W-1:0]   run_q, run_d;
  logic [lcg_pkg::LEN_W-1:0]    left_q, left_d;
  logic [lcg_pkg::LEN_W-1:0]    len_q, len_d;
  logic [lcg_pkg::DRAW_W-1:0]   next_val;
  lcg_pkg::draw_item_t          issue, b_q, c_q;
  logic [lcg_pkg::DRAW_W-1:0]   c_quot_q;
  logic [63:0]                  b_prod;
  logic [lcg_pkg::DRAW_W-1:0]   b_quot;
  logic [lcg_pkg::DIV_W-1:0]    c_div;
  logic [lcg_pkg::DRAW_W-1:0]   c_diff;
  logic [lcg_pkg::DIV_W-1:0]    c_rem;
  logic [6:0]                   len_full;
  logic [lcg_pkg::LEN_W-1:0]    len_res;
  logic                         en;
  logic                         out_valid_q;
  logic [lcg_pkg::CHAR_W-1:0]   char_q;
  logic [lcg_pkg::LEN_W-1:0]    slen_q;
  logic                         last_q;

  // the whole back end moves only when the output register can take a result
  assign en       = !out_valid_q || !out_stall_i;
  assign next_val = lcg_pkg::lcg_next(run_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    run_d   = run_q;
    left_d  = left_q;
    len_d   = len_q;
    pop_o   = 1'b0;
    issue   = '0;
    if (en) begin
      unique case (state_q)
        lcg_pkg::ST_IDLE: begin
          if (tok_avail_i) begin
            pop_o        = 1'b1;
            run_d        = next_val;
            issue.valid  = 1'b1;
            issue.is_len = 1'b1;
            issue.draw   = next_val;
            state_d      = lcg_pkg::ST_LEN_WAIT;
          end
        end
        lcg_pkg::ST_LEN_WAIT: begin
          if (c_q.valid && c_q.is_len) begin
            left_d  = len_res;
            len_d   = len_res;
            state_d = lcg_pkg::ST_CHARS;
          end
        end
        lcg_pkg::ST_CHARS: begin
          run_d       = next_val;
          issue.valid = 1'b1;
          issue.last  = (left_q == lcg_pkg::LEN_W'(1));
          issue.len   = len_q;
          issue.draw  = next_val;
          left_d      = left_q - 1'b1;
          if (left_q == lcg_pkg::LEN_W'(1)) begin
            state_d = lcg_pkg::ST_IDLE;
          end
        end
        default: state_d = lcg_pkg::ST_IDLE;
      endcase
    end
    if (seed_we_i) begin
      run_d = seed_value_i;
    end
  end

  // quotient by reciprocal multiply, exact for every 31-bit draw
  assign b_prod = 64'(b_q.draw) * (b_q.is_len ? 64'(lcg_pkg::SPAN_RECIP)
                                              : 64'(lcg_pkg::ALPHA_RECIP));
  assign b_quot = b_q.is_len ? 31'(b_prod >> (lcg_pkg::DRAW_W + lcg_pkg::SPAN_SHIFT))
                             : 31'(b_prod >> (lcg_pkg::DRAW_W + lcg_pkg::ALPHA_SHIFT));

  // remainder and length
  assign c_div    = c_q.is_len ? lcg_pkg::DIV_W'(lcg_pkg::LENGTH_SPAN)
                               : lcg_pkg::DIV_W'(lcg_pkg::ALPHABET_SIZE);
  assign c_diff   = c_q.draw - 31'(37'(c_quot_q) * 37'(c_div));
  assign c_rem    = c_diff[lcg_pkg::DIV_W-1:0];
  assign len_full = 7'(c_rem) + 7'(lcg_pkg::MIN_LENGTH);
  assign len_res  = (len_full > 7'(lcg_pkg::MAX_CHARS)) ? lcg_pkg::LEN_W'(lcg_pkg::MAX_CHARS)
                                                       : len_full[lcg_pkg::LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcg_pkg::ST_IDLE;
      run_q       <= lcg_pkg::SEED_RESET;
      left_q      <= '0;
      len_q       <= '0;
      b_q         <= '0;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      left_q  <= left_d;
      len_q   <= len_d;
      if (en) begin
        b_q         <= issue;
        c_q         <= b_q;
        out_valid_q <= c_q.valid && !c_q.is_len;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_quot_q <= b_quot;
    end
    if (en && c_q.valid && !c_q.is_len) begin
      char_q <= lcg_pkg::alpha_char(c_rem);
      slen_q <= c_q.len;
      last_q <= c_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign char_code_o     = char_q;
  assign string_length_o = slen_q;
  assign last_char_o     = last_q;

  a_chars_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcg_pkg::ST_CHARS) |-> (left_q != '0))
    else $error("character phase with nothing left to draw");

  a_len_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_q.valid && c_q.is_len) |-> (state_q == lcg_pkg::ST_LEN_WAIT))
    else $error("length draw resolved outside the wait phase");

endmodule

// File: test/lcg_string_checker.sv
// scoreboard for the lcg string generator: predicts each string and checks every character
module lcg_string_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_stall_i,
  input  logic                          request_i,
  input  logic                          chr_valid_i,
  input  logic                          chr_stall_i,
  input  logic [lcg_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [lcg_pkg::LEN_W-1:0]     string_length_i,
  input  logic                          last_char_i,
  input  logic                          seed_we_i,
  input  logic [lcg_pkg::DRAW_W-1:0]    seed_value_i,
  output int                            pending_o,
  output int                            errors_o,
  output int                            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lcg_pkg::CHAR_W-1:0] code;
    logic [lcg_pkg::LEN_W-1:0]  len;
    logic                       last;
  } string_char_t;

  string_char_t               expected_chars[$];
  logic [lcg_pkg::DRAW_W-1:0] gen_state;
  int                         error_count;
  int                         checked_count;

  // one generator step, reduced mod 2^31-1 with full-width arithmetic
  function automatic logic [lcg_pkg::DRAW_W-1:0] lcg_advance(
      input logic [lcg_pkg::DRAW_W-1:0] s);
    logic [63:0] acc;
    acc = {33'd0, s} * {32'd0, lcg_pkg::LCG_MUL} + {32'd0, lcg_pkg::LCG_INC};
    acc = acc % {32'd0, lcg_pkg::LCG_MOD};
    return acc[lcg_pkg::DRAW_W-1:0];
  endfunction

  // index 0..61 into lowercase, uppercase, digits
  function automatic logic [lcg_pkg::CHAR_W-1:0] alnum_code(input int unsigned idx);
    int unsigned code;
    if (idx < lcg_pkg::NUM_LOWER) begin
      code = lcg_pkg::ASCII_LOW_A + idx;
    end else if (idx < lcg_pkg::NUM_LETTERS) begin
      code = lcg_pkg::ASCII_UP_A + (idx - lcg_pkg::NUM_LOWER);
    end else begin
      code = lcg_pkg::ASCII_ZERO + (idx - lcg_pkg::NUM_LETTERS);
    end
    return code[lcg_pkg::CHAR_W-1:0];
  endfunction

  function automatic void predict_string();
    int unsigned  len;
    string_char_t c;
    gen_state = lcg_advance(gen_state);
    len = (gen_state % lcg_pkg::LENGTH_SPAN) + lcg_pkg::MIN_LENGTH;
    if (len > lcg_pkg::MAX_CHARS) begin
      len = lcg_pkg::MAX_CHARS;
    end
    for (int unsigned k = 0; k < len; k++) begin
      gen_state = lcg_advance(gen_state);
      c.code = alnum_code(gen_state % lcg_pkg::ALPHABET_SIZE);
      c.len  = len[lcg_pkg::LEN_W-1:0];
      c.last = (k == len - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void note_error();
    error_count++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    string_char_t want;
    if (!rst_ni) begin
      gen_state = lcg_pkg::SEED_RESET;
      expected_chars.delete();
      error_count = 0;
      checked_count = 0;
      pending_o <= 0;
      errors_o <= 0;
      checked_o <= 0;
    end else begin
      // output transfer first: it can only belong to strings already queued
      if (chr_valid_i && !chr_stall_i) begin
        if (expected_chars.size() == 0) begin
          note_error();
          $display("%0t: unexpected char: got code %0d len %0d last %0d",
                   $time, char_code_i, string_length_i, last_char_i);
        end else begin
          want = expected_chars.pop_front();
          checked_count++;
          if (want.code !== char_code_i || want.len !== string_length_i ||
              want.last !== last_char_i) begin
            note_error();
            $display("%0t: char %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     $time, checked_count, want.code, want.len, want.last,
                     char_code_i, string_length_i, last_char_i);
          end
        end
      end
      if (seed_we_i) begin
        gen_state = seed_value_i;
      end
      // a transfer with request low is dropped and leaves the generator alone
      if (req_valid_i && !req_stall_i && request_i) begin
        predict_string();
      end
      pending_o <= expected_chars.size();
      errors_o <= error_count;
      checked_o <= checked_count;
    end
  end

endmodule

// File: test/tb.sv
// testbench top for the lcg string generator: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                         CYCLE_LIMIT = 400000;
  localparam int                         DRAIN_PAD   = 20;
  localparam int                         NUM_BLOCKS  = 7;
  localparam int                         BLOCK_ITEMS = 38;
  localparam logic [lcg_pkg::DRAW_W-1:0] SEED_MOD    = 31'h7FFF_FFFF;
  localparam logic [lcg_pkg::DRAW_W-1:0] SEED_TOP    = 31'h7FFF_FFFE;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         request_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [lcg_pkg::CHAR_W-1:0]   char_code_o;
  logic [lcg_pkg::LEN_W-1:0]    string_length_o;
  logic                         last_char_o;
  logic                         seed_we_i = 1'b0;
  logic [lcg_pkg::DRAW_W-1:0]   seed_value_i = '0;

  int pending;
  int errors;
  int chars_checked;
  int idle_odds = 0;
  int stall_left = 0;
  int cycles = 0;
  int strings_sent = 0;
  int dropped_sent = 0;
  int seed_loads = 0;

  lcg_random_string_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .request_i       (request_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .char_code_o     (char_code_o),
    .string_length_o (string_length_o),
    .last_char_o     (last_char_o),
    .seed_we_i       (seed_we_i),
    .seed_value_i    (seed_value_i)
  );

  lcg_string_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (in_valid_i),
    .req_stall_i     (in_stall_o),
    .request_i       (request_i),
    .chr_valid_i     (out_valid_o),
    .chr_stall_i     (out_stall_i),
    .char_code_i     (char_code_o),
    .string_length_i (string_length_o),
    .last_char_i     (last_char_o),
    .seed_we_i       (seed_we_i),
    .seed_value_i    (seed_value_i),
    .pending_o       (pending),
    .errors_o        (errors),
    .checked_o       (chars_checked)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts whose length is drawn at random into stall_left
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left <= $urandom_range(1, 9);
      end
    end
  end

  task automatic send_item(input logic want);
    int gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      request_i <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    request_i <= want;
    do @(posedge clk_i); while (in_stall_o);
    if (want) begin
      strings_sent++;
    end else begin
      dropped_sent++;
    end
  endtask

  // hold off until every predicted character has been seen, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic load_seed(input logic [lcg_pkg::DRAW_W-1:0] value);
    seed_we_i <= 1'b1;
    seed_value_i <= value;
    @(posedge clk_i);
    seed_we_i <= 1'b0;
    seed_loads++;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset seed, a dropped request in between, then the seed extremes
    repeat (3) send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    settle();
    load_seed('0);
    repeat (3) send_item(1'b1);
    settle();
    // seed equal to the modulus gets folded back by the first step
    load_seed(SEED_MOD);
    repeat (3) send_item(1'b1);
    settle();
    load_seed(SEED_TOP);
    repeat (2) send_item(1'b1);
    settle();
    load_seed(lcg_pkg::SEED_RESET);
    repeat (2) send_item(1'b1);
    settle();

    for (int b = 0; b < NUM_BLOCKS; b++) begin
      case (b % 3)
        0:       idle_odds <= (b == NUM_BLOCKS - 1) ? 0 : 4;
        1:       idle_odds <= 10;
        default: idle_odds <= 0;
      endcase
      case (b)
        1:       load_seed(SEED_MOD);
        3:       load_seed('0);
        5:       load_seed(SEED_TOP);
        default: load_seed(31'($urandom_range(0, 32'h7FFF_FFFF)));
      endcase
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(1'b0);
        end
        send_item(1'b1);
      end
      settle();
    end

    $display("covered %0d strings and %0d dropped requests over %0d seed loads",
             strings_sent, dropped_sent, seed_loads);
    $display("checked %0d characters in %0d cycles", chars_checked, cycles);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: lcg_random_string_generator.f
hdl/lcg_pkg.sv
hdl/lcg_front.sv
hdl/lcg_back.sv
hdl/lcg_random_string_generator.sv
test/lcg_string_checker.sv
test/tb.sv
